@@ hw/rtl/pipc_pkg.sv @@
// ----------------------------------------------------------------------------
// pipc_pkg
// Shared types and constants for the panel input poll conditioner.
// ----------------------------------------------------------------------------
package pipc_pkg;

    localparam int ADC_BITS_DEF       = 12;
    localparam int LOG_FRAC_BITS_DEF  = 6;

    localparam int SAMPLE_W  = 12;
    localparam int READING_W = 16;
    localparam int LEVEL_W   = 7;
    localparam int BRIGHT_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [READING_W-1:0] LIGHT_FULL_LIMIT = 16'd1600;
    localparam logic [13:0]          CURVE_GAIN_Q8    = 14'd11236;
    localparam logic [15:0]          CURVE_OFFSET_Q8  = 16'd53760;
    localparam logic [BRIGHT_W-1:0]  BRIGHT_RESET     = 8'h9F;
    localparam logic [BRIGHT_W-1:0]  BRIGHT_MAX       = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_DEADBAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_POLLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_DIVIDER    = 2'd2;

    // per-tick fields that ride alongside the brightness target pipeline
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               light_valid;
        logic               card_level;
        logic               card_mounted;
    } item_t;

endpackage

@@ hw/rtl/panel_input_poll_conditioner_top.sv @@
// ----------------------------------------------------------------------------
// panel_input_poll_conditioner_top
// Per poll tick: volume level with deadband, light-to-brightness target,
// card-detect debounce, and a one-step brightness ramp.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | volume_sample, light_valid, light_reading,
//          |                      | card_level, card_mounted
//  out     | out_valid/out_ready  | sampled, volume_set, volume_level,
//          |                      | brightness_changed, brightness_level,
//          |                      | card_insert, card_eject, ramp_idle
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// One tick per cycle while the output is not stalled. A result passes through
// an input stage, one squaring stage per log fraction bit, the gain multiply,
// the round/saturate stage, then the tick state update into the result
// register. A stalled output holds the whole pipe and drops in_ready. Reset
// restores the default registers and brightness 0x9F.
// ----------------------------------------------------------------------------
module panel_input_poll_conditioner_top #(
    parameter int ADC_BITS      = pipc_pkg::ADC_BITS_DEF,
    parameter int LOG_FRAC_BITS = pipc_pkg::LOG_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [pipc_pkg::SAMPLE_W-1:0]    volume_sample,
    input  logic                             light_valid,
    input  logic [pipc_pkg::READING_W-1:0]   light_reading,
    input  logic                             card_level,
    input  logic                             card_mounted,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             sampled,
    output logic                             volume_set,
    output logic [pipc_pkg::LEVEL_W-1:0]     volume_level,
    output logic                             brightness_changed,
    output logic [pipc_pkg::BRIGHT_W-1:0]    brightness_level,
    output logic                             card_insert,
    output logic                             card_eject,
    output logic                             ramp_idle,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pipc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pipc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pipc_pkg::*;

    logic                advance;
    logic [15:0]         sample_ext;
    item_t               in_item;
    logic                pipe_valid;
    item_t               pipe_item;
    logic [BRIGHT_W-1:0] pipe_target;

    // configuration
    logic [6:0] deadband_reg;
    logic [2:0] debounce_reg;
    logic [3:0] divider_reg;

    // tick state
    logic [LEVEL_W-1:0]  volume_last_reg, volume_last_next;
    logic                volume_seen_reg, volume_seen_next;
    logic                card_last_reg, card_last_next;
    logic                card_seen_reg, card_seen_next;
    logic [2:0]          card_count_reg, card_count_next;
    logic [BRIGHT_W-1:0] bright_now_reg, bright_now_next;
    logic [BRIGHT_W-1:0] bright_goal_reg, bright_goal_next;
    logic [3:0]          phase_reg, phase_next;

    // result register
    logic                out_valid_reg;
    logic                sampled_reg, sampled_next;
    logic                vset_reg, vset_next;
    logic [LEVEL_W-1:0]  vlevel_reg, vlevel_next;
    logic                changed_reg, changed_next;
    logic                insert_reg, insert_next;
    logic                eject_reg, eject_next;

    logic [LEVEL_W-1:0]  vol_diff;
    logic                fire;
    logic [3:0]          phase_inc;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign cfg_ready = 1'b1;

    assign sample_ext = 16'(volume_sample);

    always_comb
    begin
        in_item.level        = sample_ext[ADC_BITS-1 -: LEVEL_W];
        in_item.light_valid  = light_valid;
        in_item.card_level   = card_level;
        in_item.card_mounted = card_mounted;
    end

    pipc_target_pipe #(
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_target_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_valid      (in_valid),
        .in_item       (in_item),
        .light_reading (light_reading),
        .out_valid     (pipe_valid),
        .out_item      (pipe_item),
        .out_target    (pipe_target)
    );

    always_comb
    begin
        volume_last_next = volume_last_reg;
        volume_seen_next = volume_seen_reg;
        card_last_next   = card_last_reg;
        card_seen_next   = card_seen_reg;
        card_count_next  = card_count_reg;
        bright_goal_next = bright_goal_reg;
        bright_now_next  = bright_now_reg;
        phase_next       = '0;
        sampled_next     = 1'b0;
        vset_next        = 1'b0;
        vlevel_next      = '0;
        changed_next     = 1'b0;
        insert_next      = 1'b0;
        eject_next       = 1'b0;
        fire             = 1'b0;
        phase_inc        = phase_reg + 4'd1;

        vol_diff = (pipe_item.level > volume_last_reg) ? pipe_item.level - volume_last_reg
                                                       : volume_last_reg - pipe_item.level;

        if (phase_reg == 4'd0)
        begin
            sampled_next = 1'b1;
            vlevel_next  = pipe_item.level;
            if (!volume_seen_reg || vol_diff > deadband_reg)
            begin
                vset_next        = 1'b1;
                volume_last_next = pipe_item.level;
                volume_seen_next = 1'b1;
            end

            if (pipe_item.light_valid)
            begin
                bright_goal_next = pipe_target;
            end

            // a change restarts the stable run; the event fires once per run
            if (!card_seen_reg || card_last_reg != pipe_item.card_level)
            begin
                card_last_next  = pipe_item.card_level;
                card_seen_next  = 1'b1;
                card_count_next = '0;
                fire            = debounce_reg == 3'd0;
            end
            else if (card_count_reg < debounce_reg)
            begin
                card_count_next = card_count_reg + 3'd1;
                fire            = card_count_next == debounce_reg;
            end

            if (fire)
            begin
                if (!card_last_next)
                begin
                    insert_next = 1'b1;
                end
                else if (pipe_item.card_mounted)
                begin
                    eject_next = 1'b1;
                end
            end
        end

        if (bright_now_reg != bright_goal_next)
        begin
            bright_now_next = (bright_now_reg < bright_goal_next) ? bright_now_reg + 8'd1
                                                                  : bright_now_reg - 8'd1;
            changed_next    = 1'b1;
            phase_next      = (phase_inc >= divider_reg) ? 4'd0 : phase_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg <= 7'd1;
            debounce_reg <= 3'd3;
            divider_reg  <= 4'd10;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_VOLUME_DEADBAND: deadband_reg <= cfg_data;
                CFG_DEBOUNCE_POLLS:  debounce_reg <= cfg_data[2:0];
                CFG_POLL_DIVIDER:    divider_reg  <= cfg_data[3:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_last_reg <= '0;
            volume_seen_reg <= 1'b0;
            card_last_reg   <= 1'b0;
            card_seen_reg   <= 1'b0;
            card_count_reg  <= '0;
            bright_now_reg  <= BRIGHT_RESET;
            bright_goal_reg <= BRIGHT_RESET;
            phase_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= pipe_valid;
            if (pipe_valid)
            begin
                volume_last_reg <= volume_last_next;
                volume_seen_reg <= volume_seen_next;
                card_last_reg   <= card_last_next;
                card_seen_reg   <= card_seen_next;
                card_count_reg  <= card_count_next;
                bright_now_reg  <= bright_now_next;
                bright_goal_reg <= bright_goal_next;
                phase_reg       <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && pipe_valid)
        begin
            sampled_reg <= sampled_next;
            vset_reg    <= vset_next;
            vlevel_reg  <= vlevel_next;
            changed_reg <= changed_next;
            insert_reg  <= insert_next;
            eject_reg   <= eject_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign sampled            = sampled_reg;
    assign volume_set         = vset_reg;
    assign volume_level       = vlevel_reg;
    assign brightness_changed = changed_reg;
    assign brightness_level   = bright_now_reg;
    assign card_insert        = insert_reg;
    assign card_eject         = eject_reg;
    assign ramp_idle          = !changed_reg;

endmodule

@@ hw/rtl/pipc_target_pipe.sv @@
// ----------------------------------------------------------------------------
// pipc_target_pipe
// Light reading to brightness target: log2 by repeated squaring, one fraction
// bit per stage, then gain/offset multiply and a round/saturate stage.
// ----------------------------------------------------------------------------
module pipc_target_pipe #(
    parameter int LOG_FRAC_BITS = pipc_pkg::LOG_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            in_valid,
    input  pipc_pkg::item_t                 in_item,
    input  logic [pipc_pkg::READING_W-1:0]  light_reading,
    output logic                            out_valid,
    output pipc_pkg::item_t                 out_item,
    output logic [pipc_pkg::BRIGHT_W-1:0]   out_target
);
    import pipc_pkg::*;

    localparam int NSQ       = LOG_FRAC_BITS;
    localparam int L_W       = 4 + LOG_FRAC_BITS;
    localparam int POS_W     = 18 + LOG_FRAC_BITS;
    localparam int RND_SHIFT = 8 + LOG_FRAC_BITS;
    localparam int V_W       = POS_W + 1 - RND_SHIFT;
    localparam logic [POS_W-1:0] NEG  = POS_W'(CURVE_OFFSET_Q8) << LOG_FRAC_BITS;
    localparam logic [POS_W:0]   HALF = (POS_W + 1)'(1) << (RND_SHIFT - 1);

    // stage 0 is the input register, stage k holds k fraction bits
    logic                     vld_reg  [0:NSQ];
    item_t                    item_reg [0:NSQ];
    logic [3:0]               exp_reg  [0:NSQ];
    logic [15:0]              mant_reg [0:NSQ];
    logic [LOG_FRAC_BITS-1:0] frac_reg [0:NSQ];
    logic                     full_reg [0:NSQ];
    logic                     zero_reg [0:NSQ];

    logic [16:0]              sq        [1:NSQ];
    logic [15:0]              mant_next [1:NSQ];
    logic [LOG_FRAC_BITS-1:0] frac_next [1:NSQ];

    logic                     vld_p_reg;
    item_t                    item_p_reg;
    logic                     full_p_reg;
    logic                     zero_p_reg;
    logic [POS_W-1:0]         pos_reg;

    logic                     vld_t_reg;
    item_t                    item_t_reg;
    logic [BRIGHT_W-1:0]      tgt_reg;

    logic [3:0]               exp_in;
    logic [15:0]              mant_in;
    logic [L_W-1:0]           log_val;
    logic [POS_W-1:0]         pos_next;
    logic [POS_W-1:0]         diff;
    logic [POS_W:0]           rnd;
    logic [V_W-1:0]           v;
    logic [BRIGHT_W-1:0]      tgt_next;

    // top set bit; bit 0 is never tested, so zero and one both give 0
    always_comb
    begin
        exp_in = 4'd0;
        for (int i = 1; i < READING_W; i++)
        begin
            if (light_reading[i])
            begin
                exp_in = 4'(i);
            end
        end
        mant_in = light_reading << (4'd15 - exp_in);
    end

    always_comb
    begin
        for (int k = 1; k <= NSQ; k++)
        begin
            sq[k] = 17'((32'(mant_reg[k-1]) * 32'(mant_reg[k-1])) >> 15);
            mant_next[k] = sq[k][16] ? sq[k][16:1] : sq[k][15:0];
            frac_next[k] = {frac_reg[k-1][LOG_FRAC_BITS-2:0], sq[k][16]};
        end
    end

    assign log_val  = {exp_reg[NSQ], frac_reg[NSQ]};
    assign pos_next = POS_W'(CURVE_GAIN_Q8) * POS_W'(log_val);

    always_comb
    begin
        diff = pos_reg - NEG;
        rnd  = (POS_W + 1)'(diff) + HALF;
        v    = V_W'(rnd >> RND_SHIFT);
        if (full_p_reg)
        begin
            tgt_next = BRIGHT_MAX;
        end
        else if (zero_p_reg || pos_reg <= NEG)
        begin
            tgt_next = '0;
        end
        else if (v > V_W'(BRIGHT_MAX))
        begin
            tgt_next = BRIGHT_MAX;
        end
        else
        begin
            tgt_next = v[BRIGHT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NSQ; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            vld_p_reg <= 1'b0;
            vld_t_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= NSQ; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            vld_p_reg <= vld_reg[NSQ];
            vld_t_reg <= vld_p_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg[0] <= in_item;
            exp_reg[0]  <= exp_in;
            mant_reg[0] <= mant_in;
            frac_reg[0] <= '0;
            full_reg[0] <= light_reading > LIGHT_FULL_LIMIT;
            zero_reg[0] <= light_reading == '0;
            for (int k = 1; k <= NSQ; k++)
            begin
                item_reg[k] <= item_reg[k-1];
                exp_reg[k]  <= exp_reg[k-1];
                mant_reg[k] <= mant_next[k];
                frac_reg[k] <= frac_next[k];
                full_reg[k] <= full_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
            item_p_reg <= item_reg[NSQ];
            full_p_reg <= full_reg[NSQ];
            zero_p_reg <= zero_reg[NSQ];
            pos_reg    <= pos_next;
            item_t_reg <= item_p_reg;
            tgt_reg    <= tgt_next;
        end
    end

    assign out_valid  = vld_t_reg;
    assign out_item   = item_t_reg;
    assign out_target = tgt_reg;

endmodule

@@ tb/panel_input_poll_conditioner_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panel_input_poll_conditioner_top_tb
// Drives poll ticks through the conditioner under random source gaps and sink
// stalls. A local tick model predicts every result: volume deadband, light
// to brightness curve, card debounce, brightness ramp and phase counter.
// ----------------------------------------------------------------------------
module panel_input_poll_conditioner_top_tb;

    import pipc_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_CYCLES = 11;
    localparam int PIPE_DEPTH  = LOG_FRAC_BITS_DEF + 3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 80;

    // brightness curve in Q8 with LOG_FRAC_BITS_DEF fraction bits of log2
    localparam longint unsigned LUX_GAIN   = 64'd11236;
    localparam longint unsigned LUX_OFFSET = 64'd53760;
    localparam int unsigned     LUX_FULL   = 1600;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  volume_sample;
        logic                 light_valid;
        logic [READING_W-1:0] light_reading;
        logic                 card_level;
        logic                 card_mounted;
    } poll_tick_t;

    typedef struct packed {
        logic                sampled;
        logic                volume_set;
        logic [LEVEL_W-1:0]  volume_level;
        logic                brightness_changed;
        logic [BRIGHT_W-1:0] brightness_level;
        logic                card_insert;
        logic                card_eject;
        logic                ramp_idle;
    } tick_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [SAMPLE_W-1:0]   volume_sample;
    logic                  light_valid;
    logic [READING_W-1:0]  light_reading;
    logic                  card_level;
    logic                  card_mounted;
    logic                  out_valid;
    logic                  out_ready;
    logic                  sampled;
    logic                  volume_set;
    logic [LEVEL_W-1:0]    volume_level;
    logic                  brightness_changed;
    logic [BRIGHT_W-1:0]   brightness_level;
    logic                  card_insert;
    logic                  card_eject;
    logic                  ramp_idle;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    panel_input_poll_conditioner_top i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .volume_sample      (volume_sample),
        .light_valid        (light_valid),
        .light_reading      (light_reading),
        .card_level         (card_level),
        .card_mounted       (card_mounted),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .sampled            (sampled),
        .volume_set         (volume_set),
        .volume_level       (volume_level),
        .brightness_changed (brightness_changed),
        .brightness_level   (brightness_level),
        .card_insert        (card_insert),
        .card_eject         (card_eject),
        .ramp_idle          (ramp_idle),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // tick model state and register copies
    logic [LEVEL_W-1:0]  deadband_r;
    logic [2:0]          debounce_r;
    logic [3:0]          divider_r;
    logic [LEVEL_W-1:0]  vol_last;
    logic                vol_seen;
    logic                card_last;
    logic                card_seen;
    logic [2:0]          card_count;
    logic [BRIGHT_W-1:0] bright_now;
    logic [BRIGHT_W-1:0] bright_goal;
    logic [3:0]          poll_phase;

    poll_tick_t   tick_queue[$];
    tick_result_t predicted_outs[$];

    int  cycles;
    int  errors;
    int  ticks_checked;
    int  n_sampled;
    int  n_volume;
    int  n_insert;
    int  n_eject;
    int  n_steps;
    int  n_settings;
    logic in_taken;
    int  idle_pct;
    bit  hold_req;
    int  hold_cnt;
    int  send_gap;
    int  stall_cnt;

    // stimulus generator state
    int   knob;
    logic card_now;
    int   card_run;

    always #(CLK_HALF) clk = ~clk;

    function automatic int unsigned light_log2(input logic [15:0] r);
        int unsigned       e;
        int unsigned       frac;
        longint unsigned   mant;
        longint unsigned   sq;
        int                i;
        e = 15;
        frac = 0;
        while (e > 0 && r[e] == 1'b0)
            e--;
        mant = (longint'(r) << (15 - e)) & 64'hFFFF;
        for (i = 0; i < LOG_FRAC_BITS_DEF; i++)
        begin
            sq = (mant * mant) >> 15;
            frac = frac << 1;
            // a square of 2.0 or more yields a one bit
            if (sq >= 64'h10000)
            begin
                frac = frac | 1;
                sq = sq >> 1;
            end
            mant = sq;
        end
        return (e << LOG_FRAC_BITS_DEF) | frac;
    endfunction

    function automatic logic [BRIGHT_W-1:0] lux_to_goal(input logic [15:0] r);
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned v;
        if (r > LUX_FULL)
            return 8'hFF;
        if (r == 0)
            return 8'h00;
        pos = LUX_GAIN * longint'(light_log2(r));
        neg = LUX_OFFSET << LOG_FRAC_BITS_DEF;
        if (pos <= neg)
            return 8'h00;
        v = (pos - neg + (64'd1 << (8 + LOG_FRAC_BITS_DEF - 1))) >> (8 + LOG_FRAC_BITS_DEF);
        return (v > 255) ? 8'hFF : v[7:0];
    endfunction

    function automatic tick_result_t advance_tick(input poll_tick_t t);
        tick_result_t       r;
        logic [LEVEL_W-1:0] lvl;
        int unsigned        diff;
        logic               fire;
        r = '0;
        fire = 1'b0;
        if (poll_phase == 4'd0)
        begin
            lvl = t.volume_sample[SAMPLE_W-1 -: LEVEL_W];
            r.sampled = 1'b1;
            r.volume_level = lvl;
            diff = (lvl > vol_last) ? int'(lvl) - int'(vol_last) : int'(vol_last) - int'(lvl);
            if (!vol_seen || diff > deadband_r)
            begin
                r.volume_set = 1'b1;
                vol_last = lvl;
                vol_seen = 1'b1;
            end
            if (t.light_valid)
                bright_goal = lux_to_goal(t.light_reading);
            if (!card_seen || card_last != t.card_level)
            begin
                card_last = t.card_level;
                card_seen = 1'b1;
                card_count = 3'd0;
                fire = (debounce_r == 3'd0);
            end
            else if (card_count < debounce_r)
            begin
                card_count = card_count + 3'd1;
                fire = (card_count == debounce_r);
            end
            if (fire)
            begin
                if (card_last == 1'b0)
                    r.card_insert = 1'b1;
                else if (t.card_mounted)
                    r.card_eject = 1'b1;
            end
        end
        if (bright_now != bright_goal)
        begin
            if (bright_now < bright_goal)
                bright_now = bright_now + 8'd1;
            else
                bright_now = bright_now - 8'd1;
            r.brightness_changed = 1'b1;
            poll_phase = poll_phase + 4'd1;
            if (poll_phase >= divider_r)
                poll_phase = 4'd0;
        end
        else
        begin
            poll_phase = 4'd0;
        end
        r.brightness_level = bright_now;
        r.ramp_idle = ~r.brightness_changed;
        return r;
    endfunction

    // predictor on input transfers, checker on output transfers
    always @(posedge clk)
    begin
        tick_result_t want;
        tick_result_t got;
        poll_tick_t   t;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     predicted_outs.size());
            $display("panel_input_poll_conditioner_top: mismatch");
            $finish;
        end
        in_taken <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            t = '{volume_sample, light_valid, light_reading, card_level, card_mounted};
            predicted_outs.push_back(advance_tick(t));
        end
        if (rst_n && out_valid && out_ready)
        begin
            got = '{sampled, volume_set, volume_level, brightness_changed, brightness_level,
                    card_insert, card_eject, ramp_idle};
            if (predicted_outs.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result transfer %p", $realtime, got);
            end
            else
            begin
                want = predicted_outs.pop_front();
                ticks_checked++;
                n_sampled += want.sampled;
                n_volume  += want.volume_set;
                n_insert  += want.card_insert;
                n_eject   += want.card_eject;
                n_steps   += want.brightness_changed;
                if (got.sampled !== want.sampled || got.volume_set !== want.volume_set ||
                    got.volume_level !== want.volume_level ||
                    got.brightness_changed !== want.brightness_changed ||
                    got.brightness_level !== want.brightness_level ||
                    got.card_insert !== want.card_insert || got.card_eject !== want.card_eject ||
                    got.ramp_idle !== want.ramp_idle)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("%0t: tick %0d", $realtime, ticks_checked);
                        $display("  exp smp=%b vset=%b vlvl=%0d chg=%b bri=%0d ins=%b ej=%b idle=%b",
                                 want.sampled, want.volume_set, want.volume_level,
                                 want.brightness_changed, want.brightness_level,
                                 want.card_insert, want.card_eject, want.ramp_idle);
                        $display("  got smp=%b vset=%b vlvl=%0d chg=%b bri=%0d ins=%b ej=%b idle=%b",
                                 got.sampled, got.volume_set, got.volume_level,
                                 got.brightness_changed, got.brightness_level,
                                 got.card_insert, got.card_eject, got.ramp_idle);
                    end
                end
            end
        end
    end

    // source: holds each tick until its transfer, with random gap bursts
    always @(negedge clk)
    begin
        poll_tick_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                send_gap <= $urandom_range(0, 14);
                in_valid <= 1'b0;
            end
            else if (tick_queue.size() != 0)
            begin
                nxt = tick_queue.pop_front();
                in_valid      <= 1'b1;
                volume_sample <= nxt.volume_sample;
                light_valid   <= nxt.light_valid;
                light_reading <= nxt.light_reading;
                card_level    <= nxt.card_level;
                card_mounted  <= nxt.card_mounted;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // sink: random stall bursts plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt <= HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else if (stall_cnt != 0)
        begin
            stall_cnt <= stall_cnt - 1;
            out_ready <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            stall_cnt <= $urandom_range(0, 14);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready))
            @(posedge clk);
        case (idx)
            CFG_VOLUME_DEADBAND: deadband_r = val;
            CFG_DEBOUNCE_POLLS:  debounce_r = val[2:0];
            CFG_POLL_DIVIDER:    divider_r  = val[3:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input int dband, input int dpolls, input int divider);
        write_reg(CFG_VOLUME_DEADBAND, CFG_DATA_W'(dband));
        write_reg(CFG_DEBOUNCE_POLLS, CFG_DATA_W'(dpolls));
        write_reg(CFG_POLL_DIVIDER, CFG_DATA_W'(divider));
        @(negedge clk);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic wait_drained();
        while (tick_queue.size() != 0 || in_valid || predicted_outs.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    task automatic push_tick(input int vol, input bit lv, input int rd, input bit cl, input bit cm);
        tick_queue.push_back('{SAMPLE_W'(vol), lv, READING_W'(rd), cl, cm});
    endtask

    // card level held in runs so debounce completes, with short glitches
    task automatic queue_ticks(input int count);
        poll_tick_t t;
        int         k;
        int         sel;
        for (k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 3)
                knob = $urandom_range(0, 4095);
            else
                knob = knob + $urandom_range(0, 160) - 80;
            if (knob < 0)
                knob = 0;
            if (knob > 4095)
                knob = 4095;
            t.volume_sample = knob[SAMPLE_W-1:0];
            sel = $urandom_range(0, 15);
            if (sel == 0)
                t.light_reading = '0;
            else if (sel < 3)
                t.light_reading = READING_W'($urandom_range(1540, 1610));
            else if (sel < 7)
                t.light_reading = READING_W'($urandom_range(0, 65535));
            else if (sel < 14)
                t.light_reading = READING_W'($urandom_range(1, 1600));
            else
                t.light_reading = READING_W'($urandom_range(1, 16));
            t.light_valid = ($urandom_range(0, 7) != 0);
            if (card_run == 0)
            begin
                if ($urandom_range(0, 9) != 0)
                    card_now = ~card_now;
                card_run = $urandom_range(1, 14);
            end
            card_run--;
            t.card_level = ($urandom_range(0, 19) == 0) ? ~card_now : card_now;
            t.card_mounted = ($urandom_range(0, 4) != 0);
            tick_queue.push_back(t);
        end
    endtask

    initial
    begin
        int dband_set[10];
        int dpoll_set[10];
        int div_set[10];
        int p;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        volume_sample = '0;
        light_valid = 1'b0;
        light_reading = '0;
        card_level = 1'b1;
        card_mounted = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_VOLUME_DEADBAND;
        cfg_data = '0;
        in_taken = 1'b0;
        cycles = 0;
        errors = 0;
        ticks_checked = 0;
        n_sampled = 0;
        n_volume = 0;
        n_insert = 0;
        n_eject = 0;
        n_steps = 0;
        n_settings = 1;
        idle_pct = 10;
        hold_req = 1'b0;
        hold_cnt = 0;
        send_gap = 0;
        stall_cnt = 0;
        knob = 2048;
        card_now = 1'b1;
        card_run = 0;
        deadband_r = 7'd1;
        debounce_r = 3'd3;
        divider_r = 4'd10;
        vol_last = '0;
        vol_seen = 1'b0;
        card_last = 1'b0;
        card_seen = 1'b0;
        card_count = 3'd0;
        bright_now = 8'h9F;
        bright_goal = 8'h9F;
        poll_phase = 4'd0;
        dband_set = '{0, 127, 1, 3, 0, 2, 8, 1, 4, 0};
        dpoll_set = '{0, 7, 1, 2, 5, 3, 6, 4, 7, 1};
        div_set   = '{0, 15, 1, 2, 15, 5, 0, 7, 12, 3};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset register values first
        queue_ticks(30);
        wait_drained();

        // directed: sample every tick
        idle_pct = 0;
        program_regs(1, 2, 0);
        push_tick(0, 1, 0, 1, 1);         // level 0, reading of zero gives target zero
        push_tick(4095, 1, 65535, 1, 1);  // full-scale volume, bright saturates
        push_tick(4095, 1, 1, 1, 1);      // reading of one -> zero, eject on stable run
        push_tick(4063, 1, 1600, 1, 1);   // level 126: inside deadband
        push_tick(4031, 1, 1601, 0, 1);   // level 125 sent; above limit
        push_tick(4031, 1, 1548, 0, 1);   // curve edge, just below the overflow band
        push_tick(4031, 0, 65535, 0, 0);  // invalid reading keeps target; insert fires
        push_tick(2048, 1, 1000, 0, 0);
        push_tick(2048, 1, 2, 1, 0);      // card removed while unmounted
        push_tick(2048, 1, 1590, 1, 0);
        push_tick(2048, 1, 1580, 1, 0);   // debounce done, no eject when unmounted
        push_tick(31, 1, 40, 0, 1);
        wait_drained();

        // lower the divider below a running phase, then debounce of zero
        idle_pct = 5;
        program_regs(0, 2, 15);
        push_tick(100, 1, (bright_now > 8'd127) ? 0 : 65535, 1, 1);
        repeat (5) push_tick(3000, 0, 0, 1, 1);
        wait_drained();
        program_regs(3, 0, 2);
        push_tick(500, 0, 0, 0, 1);
        push_tick(600, 0, 0, 1, 1);
        push_tick(700, 0, 0, 0, 1);
        push_tick(800, 0, 0, 1, 1);
        push_tick(900, 0, 0, 1, 1);
        push_tick(1000, 0, 0, 0, 1);
        wait_drained();

        for (p = 0; p < 10; p++)
        begin
            case (p % 4)
                0: idle_pct = 3;
                1: idle_pct = 15;
                2: idle_pct = 30;
                default: idle_pct = 0;
            endcase
            if (p == 9)
                idle_pct = 0;
            program_regs(dband_set[p], dpoll_set[p], div_set[p]);
            queue_ticks(86);
            if (p == 3)
            begin
                repeat (5) @(posedge clk);
                hold_req = 1'b1;
            end
            wait_drained();
        end

        repeat (4 * PIPE_DEPTH) @(posedge clk);
        $display("Summary: %0d ticks over %0d register settings; %0d sampled, %0d volume writes",
                 ticks_checked, n_settings, n_sampled, n_volume);
        $display("  %0d card inserts, %0d ejects, %0d brightness steps, %0d mismatches",
                 n_insert, n_eject, n_steps, errors);
        if (errors == 0 && predicted_outs.size() == 0)
            $display("panel_input_poll_conditioner_top: match");
        else
            $display("panel_input_poll_conditioner_top: mismatch");
        $finish;
    end

endmodule
